// File: src/lifeg_pkg.sv
// Shared types, constants and helper functions for the Life generation block.
// No dependencies; lifeg_out and the top level import this package.
package lifeg_pkg;

  localparam int ROW_W        = 10;   // row index width
  localparam int CFG_WW       = 6;    // grid_width register width
  localparam int CFG_HW       = 10;   // grid_height register width
  localparam int CFG_DATA_W   = 10;   // widest register
  localparam int SIZE_MIN     = 3;    // smallest usable width or height
  localparam int GRID_W_RST   = 20;
  localparam int GRID_H_RST   = 10;
  localparam int NBR_W        = 4;    // neighbor count 0..8
  localparam int BIRTH_COUNT  = 3;
  localparam int KEEP_COUNT   = 2;

  typedef enum logic [0:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

  // Pending results produced by one input beat
  typedef struct packed {
    logic a_v;      // result for the cell one row up, one column left
    logic a_alive;
    logic b_v;      // last column of the row above
    logic bu_v;     // whole last row of the generation
  } job_flags_t;

  function automatic logic [NBR_W-1:0] nbr_count(input logic [7:0] bits);
    logic [NBR_W-1:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + NBR_W'(bits[i]);
    end
    return n;
  endfunction

  // B3/S23
  function automatic logic life_rule(input logic centre, input logic [NBR_W-1:0] n);
    return (n == NBR_W'(BIRTH_COUNT)) || (centre && (n == NBR_W'(KEEP_COUNT)));
  endfunction

endpackage

// File: src/lifeg_col_cell.sv
// One column cell of the line buffers: the cell one row up and two rows up.
// Depends on nothing; instantiated once per column by the top level.
module lifeg_col_cell (
  input  logic clk,
  input  logic wr_en,
  input  logic bot_in,
  output logic above,
  output logic two_above
);

  logic above_r, above_nxt;
  logic two_r, two_nxt;

  // Push the column down one row on a write
  always_comb begin
    above_nxt = above_r;
    two_nxt   = two_r;
    if (wr_en) begin
      two_nxt   = above_r;
      above_nxt = bot_in;
    end
  end

  always_ff @(posedge clk) begin
    above_r <= above_nxt;
    two_r   <= two_nxt;
  end

  assign above     = above_r;
  assign two_above = two_r;

endmodule

// File: src/lifeg_win_cell.sv
// One 3-cell column of the 3x3 window; hands its column to the next cell.
// Depends on nothing; chained twice in the top level.
module lifeg_win_cell (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic [2:0] col_in,
  output logic [2:0] col_out
);

  logic [2:0] col_r, col_nxt;

  always_comb begin
    col_nxt = col_r;
    if (adv) begin
      col_nxt = col_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign col_out = col_r;

endmodule

// File: src/lifeg_out.sv
// Result sequencer and output register: holds the results of one input beat
// and drains them one per cycle unless the output stalls. Depends on lifeg_pkg.
module lifeg_out
  import lifeg_pkg::*;
#(
  parameter int COL_W = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  job_flags_t            job,
  input  logic [ROW_W-1:0]      job_row,
  input  logic [COL_W-1:0]      job_a_col,
  input  logic [COL_W-1:0]      job_last_col,
  output logic                  job_free,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_next_alive,
  output logic [ROW_W-1:0]      out_row,
  output logic [COL_W-1:0]      out_col,
  output logic                  out_gen_last
);

  job_flags_t         pend_r, pend_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   a_col_r, a_col_nxt;
  logic [COL_W-1:0]   last_col_r, last_col_nxt;
  logic [COL_W-1:0]   idx_r, idx_nxt;

  logic               ov_r, ov_nxt;
  logic               oa_r, oa_nxt;
  logic [ROW_W-1:0]   orow_r, orow_nxt;
  logic [COL_W-1:0]   ocol_r, ocol_nxt;
  logic               olast_r, olast_nxt;

  logic out_adv, pend_none, pend_one, idx_end, pop;
  logic               h_alive, h_last;
  logic [ROW_W-1:0]   h_row;
  logic [COL_W-1:0]   h_col;

  assign out_adv   = !ov_r || !out_stall;
  assign idx_end   = (idx_r == last_col_r);
  assign pend_none = !pend_r.a_v && !pend_r.b_v && !pend_r.bu_v;
  assign pend_one  = (pend_r.a_v && !pend_r.b_v && !pend_r.bu_v)
                  || (!pend_r.a_v && pend_r.b_v && !pend_r.bu_v)
                  || (!pend_r.a_v && !pend_r.b_v && pend_r.bu_v && idx_end);
  assign job_free  = pend_none || (pend_one && out_adv);
  assign pop       = out_adv && !pend_none;

  // Head of the pending results, in emission order
  always_comb begin
    h_alive = 1'b0;
    h_row   = row_r - ROW_W'(1);
    h_col   = last_col_r;
    h_last  = 1'b0;
    priority if (pend_r.a_v) begin
      h_alive = pend_r.a_alive;
      h_col   = a_col_r;
    end else if (pend_r.b_v) begin
      h_col   = last_col_r;
    end else begin
      h_row   = row_r;
      h_col   = idx_r;
      h_last  = idx_end;
    end
  end

  always_comb begin
    pend_nxt     = pend_r;
    row_nxt      = row_r;
    a_col_nxt    = a_col_r;
    last_col_nxt = last_col_r;
    idx_nxt      = idx_r;
    if (pop) begin
      priority if (pend_r.a_v) begin
        pend_nxt.a_v = 1'b0;
      end else if (pend_r.b_v) begin
        pend_nxt.b_v = 1'b0;
      end else if (idx_end) begin
        pend_nxt.bu_v = 1'b0;
      end else begin
        idx_nxt = idx_r + COL_W'(1);
      end
    end
    if (load) begin
      pend_nxt     = job;
      row_nxt      = job_row;
      a_col_nxt    = job_a_col;
      last_col_nxt = job_last_col;
      idx_nxt      = '0;
    end
  end

  always_comb begin
    ov_nxt    = ov_r;
    oa_nxt    = oa_r;
    orow_nxt  = orow_r;
    ocol_nxt  = ocol_r;
    olast_nxt = olast_r;
    if (out_adv) begin
      ov_nxt    = !pend_none;
      oa_nxt    = h_alive;
      orow_nxt  = h_row;
      ocol_nxt  = h_col;
      olast_nxt = h_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      idx_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      idx_r  <= idx_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    a_col_r    <= a_col_nxt;
    last_col_r <= last_col_nxt;
    oa_r       <= oa_nxt;
    orow_r     <= orow_nxt;
    ocol_r     <= ocol_nxt;
    olast_r    <= olast_nxt;
  end

  assign out_valid      = ov_r;
  assign out_next_alive = oa_r;
  assign out_row        = orow_r;
  assign out_col        = ocol_r;
  assign out_gen_last   = olast_r;

endmodule

// File: src/life_automaton_generation_top.sv
// Streaming Game of Life (B3/S23) generation engine. Cells of one generation
// enter in raster order, one alive bit per beat, and the next generation leaves
// in raster order with its row and column and a flag on the last cell. Border
// cells always come out dead. The block takes one cell per clock when the input
// is not stalled: a row of column cells (one per column, two line-buffer bits
// each) and a two-column window chain form the 3x3 neighborhood in the same
// cycle the cell arrives. Results trail the input by one row and one column and
// leave through a single output register, one per cycle unless the output
// stalls, so the beat that closes a row past the first yields two results and
// the beat that closes the generation yields W + 2; the input stalls while these
// drain. A beat's results first sit in a pending register and then pass to the
// output register. Sizes are clamped to 3..MAX_WIDTH columns and 3..1023 rows.
// Write grid_width and grid_height only while the block is idle; a size written
// mid-generation takes effect at once, and a position past the new last column
// or row is treated as that last column or row. Depends on lifeg_pkg and the
// lifeg_* modules.
module life_automaton_generation_top
  import lifeg_pkg::*;
#(
  parameter int MAX_WIDTH = 32,
  localparam int COL_W    = $clog2(MAX_WIDTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input cells
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_cell_alive,
  // next-generation cells
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_next_alive,
  output logic [ROW_W-1:0]      out_row,
  output logic [COL_W-1:0]      out_col,
  output logic                  out_gen_last
);

  localparam logic [CFG_WW-1:0] WMAX = CFG_WW'(MAX_WIDTH);

  // Configuration registers
  logic [CFG_WW-1:0] gw_r, gw_nxt;
  logic [CFG_HW-1:0] gh_r, gh_nxt;

  // Raster position of the next input beat
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0] in_col_r, in_col_nxt;

  logic [CFG_WW-1:0] w_eff, w_last6;
  logic [COL_W-1:0]  w_last, c;
  logic [CFG_HW-1:0] h_eff, h_last;
  logic [ROW_W-1:0]  r;
  logic end_col, end_row, accept, job_free;

  logic [MAX_WIDTH-1:0] lb_above, lb_two;
  logic top_bit, mid_bit;
  logic [2:0] win1, win2;
  logic [NBR_W-1:0] nbr;
  logic alive;
  job_flags_t job;

  // Config writes take effect at the next edge
  always_comb begin
    gw_nxt = gw_r;
    gh_nxt = gh_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_GRID_WIDTH:  gw_nxt = cfg_wdata[CFG_WW-1:0];
        CFG_GRID_HEIGHT: gh_nxt = cfg_wdata[CFG_HW-1:0];
      endcase
    end
  end

  // Clamp the sizes and the current position
  always_comb begin
    w_eff = gw_r;
    if (gw_r < CFG_WW'(SIZE_MIN)) begin
      w_eff = CFG_WW'(SIZE_MIN);
    end else if (gw_r > WMAX) begin
      w_eff = WMAX;
    end
    w_last6 = w_eff - CFG_WW'(1);
    w_last  = w_last6[COL_W-1:0];
    h_eff   = (gh_r < CFG_HW'(SIZE_MIN)) ? CFG_HW'(SIZE_MIN) : gh_r;
    h_last  = h_eff - CFG_HW'(1);
    c       = (CFG_WW'(in_col_r) >= w_eff) ? w_last : in_col_r;
    r       = (in_row_r >= h_eff) ? h_last : in_row_r;
    end_col = (c == w_last);
    end_row = (r == h_last);
  end

  assign in_stall = !job_free;
  assign accept   = in_valid && job_free;

  // Line-buffer column cells: the cell at column c shifts down on a beat
  for (genvar j = 0; j < MAX_WIDTH; j++) begin : g_col
    lifeg_col_cell u_cell (
      .clk       (clk),
      .wr_en     (accept && (c == COL_W'(j))),
      .bot_in    (in_cell_alive),
      .above     (lb_above[j]),
      .two_above (lb_two[j])
    );
  end

  assign top_bit = lb_two[c];
  assign mid_bit = lb_above[c];

  // Window chain: column c-1 then column c-2; bit 0 is the upper row
  lifeg_win_cell u_win1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (accept),
    .col_in  ({in_cell_alive, mid_bit, top_bit}),
    .col_out (win1)
  );

  lifeg_win_cell u_win2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (accept),
    .col_in  (win1),
    .col_out (win2)
  );

  // Neighborhood of cell (r-1, c-1); its centre is the middle of column c-1
  assign nbr   = nbr_count({win2, win1[2], win1[0], in_cell_alive, mid_bit, top_bit});
  assign alive = life_rule(win1[1], nbr);

  // Results caused by this beat
  always_comb begin
    job.a_v     = (r != '0) && (c != '0);
    job.a_alive = (r > ROW_W'(1)) && (c > COL_W'(1)) && alive;
    job.b_v     = (r != '0) && end_col;
    job.bu_v    = end_row && end_col;
  end

  // Advance the raster position, wrap at the end of the generation
  always_comb begin
    in_row_nxt = in_row_r;
    in_col_nxt = in_col_r;
    if (accept) begin
      if (end_col) begin
        in_col_nxt = '0;
        in_row_nxt = end_row ? '0 : r + ROW_W'(1);
      end else begin
        in_col_nxt = c + COL_W'(1);
        in_row_nxt = r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r     <= CFG_WW'(GRID_W_RST);
      gh_r     <= CFG_HW'(GRID_H_RST);
      in_row_r <= '0;
      in_col_r <= '0;
    end else begin
      gw_r     <= gw_nxt;
      gh_r     <= gh_nxt;
      in_row_r <= in_row_nxt;
      in_col_r <= in_col_nxt;
    end
  end

  lifeg_out #(
    .COL_W (COL_W)
  ) u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (accept),
    .job            (job),
    .job_row        (r),
    .job_a_col      (c - COL_W'(1)),
    .job_last_col   (w_last),
    .job_free       (job_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_next_alive (out_next_alive),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_gen_last   (out_gen_last)
  );

  // Cells on the first row and the first column never come out alive
  a_border_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_row == '0) |-> !out_next_alive)
    else $error("live cell emitted on the first row");

  a_border_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_col == '0) |-> !out_next_alive)
    else $error("live cell emitted on the first column");

  // The generation-closing beat is a border cell on the last column
  a_gen_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_gen_last |-> !out_next_alive && (out_col == w_last))
    else $error("generation end flagged on a wrong cell");

endmodule

// File: sim/life_generation_checker.sv
// Checker for the Life generation block: watches the size writes, the cell beats and the
// result beats, predicts each next-generation cell and compares it field by field.
// Depends on lifeg_pkg for the register codes, reset sizes and field widths.
module life_generation_checker
  import lifeg_pkg::*;
#(
  parameter int MAX_COLS = 32,
  parameter int COL_BITS = $clog2(MAX_COLS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_cell_alive,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_next_alive,
  input  logic [ROW_W-1:0]      out_row,
  input  logic [COL_BITS-1:0]   out_col,
  input  logic                  out_gen_last,
  output int                    mismatches,
  output int                    pending,
  output int                    results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                alive;
    logic [ROW_W-1:0]    row;
    logic [COL_BITS-1:0] col;
    logic                last;
  } life_cell_t;

  life_cell_t          next_cells_q[$];
  logic [CFG_WW-1:0]   grid_w;
  logic [CFG_HW-1:0]   grid_h;
  logic                row_above[MAX_COLS];
  logic                row_two_above[MAX_COLS];
  logic [5:0]          window;     // [2:0] column c-2, [5:3] column c-1, low bit = upper row
  logic [ROW_W-1:0]    row_pos;
  logic [COL_BITS-1:0] col_pos;

  task automatic queue_cell(input logic alive, input logic [ROW_W-1:0] row,
                            input logic [COL_BITS-1:0] col, input logic last);
    life_cell_t entry;
    entry.alive = alive;
    entry.row   = row;
    entry.col   = col;
    entry.last  = last;
    next_cells_q.push_back(entry);
  endtask

  // One cell beat: emit what it completes, then shift it into the buffers.
  task automatic predict_next_cells(input logic bot);
    int                  w;
    int                  h;
    logic [ROW_W-1:0]    r;
    logic [COL_BITS-1:0] c;
    logic                top;
    logic                mid;
    logic                end_col;
    logic                end_row;
    logic                alive;
    int                  n;
    w = int'(grid_w);
    h = int'(grid_h);
    if (w < SIZE_MIN) w = SIZE_MIN;
    if (w > MAX_COLS) w = MAX_COLS;
    if (h < SIZE_MIN) h = SIZE_MIN;
    r = row_pos;
    c = col_pos;
    if (int'(c) >= w) c = COL_BITS'(w - 1);
    if (int'(r) >= h) r = ROW_W'(h - 1);
    end_col = (int'(c) == w - 1);
    end_row = (int'(r) == h - 1);
    top = row_two_above[c];
    mid = row_above[c];

    if (r >= 1) begin
      if (c == 1) begin
        queue_cell(1'b0, r - ROW_W'(1), '0, 1'b0);
      end else if (c >= 2) begin
        alive = 1'b0;
        if (r >= 2) begin
          n = int'(top) + int'(mid) + int'(bot) + int'(window[0]) + int'(window[1])
            + int'(window[2]) + int'(window[3]) + int'(window[5]);
          alive = (n == 3) || (window[4] && n == 2);
        end
        queue_cell(alive, r - ROW_W'(1), c - COL_BITS'(1), 1'b0);
      end
      if (end_col) queue_cell(1'b0, r - ROW_W'(1), COL_BITS'(w - 1), 1'b0);
    end
    // closing the generation flushes the all-dead last row
    if (end_row && end_col) begin
      for (int j = 0; j < w; j++) queue_cell(1'b0, r, COL_BITS'(j), j == w - 1);
    end

    row_two_above[c] = mid;
    row_above[c]     = bot;
    window           = {bot, mid, top, window[5:3]};
    if (end_col) begin
      col_pos = '0;
      row_pos = end_row ? '0 : r + ROW_W'(1);
    end else begin
      col_pos = c + COL_BITS'(1);
      row_pos = r;
    end
  endtask

  always @(posedge clk) begin
    life_cell_t got;
    life_cell_t exp;
    if (!rst_n) begin
      next_cells_q.delete();
      grid_w  = CFG_WW'(GRID_W_RST);
      grid_h  = CFG_HW'(GRID_H_RST);
      window  = '0;
      row_pos = '0;
      col_pos = '0;
      for (int i = 0; i < MAX_COLS; i++) begin
        row_above[i]     = 1'b0;
        row_two_above[i] = 1'b0;
      end
    end else begin
      // compare first: a result can never come from the beat of this same edge
      if (out_valid && !out_stall) begin
        results_seen++;
        got.alive = out_next_alive;
        got.row   = out_row;
        got.col   = out_col;
        got.last  = out_gen_last;
        if (next_cells_q.size() == 0) begin
          if (mismatches < 10)
            $display({"mismatch: result beat with nothing expected: ",
                      "alive=%0d row=%0d col=%0d last=%0d"},
                     got.alive, got.row, got.col, got.last);
          mismatches++;
        end else begin
          exp = next_cells_q.pop_front();
          if (got.alive !== exp.alive || got.row !== exp.row || got.col !== exp.col ||
              got.last !== exp.last) begin
            if (mismatches < 10)
              $display({"mismatch: expected alive=%0d row=%0d col=%0d last=%0d, ",
                        "got alive=%0d row=%0d col=%0d last=%0d"},
                       exp.alive, exp.row, exp.col, exp.last,
                       got.alive, got.row, got.col, got.last);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_reg_t'(cfg_index) == CFG_GRID_WIDTH) grid_w = cfg_wdata[CFG_WW-1:0];
        else grid_h = cfg_wdata[CFG_HW-1:0];
      end
      if (in_valid && !in_stall) predict_next_cells(in_cell_alive);
    end
    pending = next_cells_q.size();
  end

endmodule

// File: sim/tb_life_automaton_generation_top.sv
// Testbench top for the Life generation block: drives cell beats and size writes with
// random idling on both channels, and gives the verdict from the checker's counts.
// Depends on lifeg_pkg, life_automaton_generation_top and life_generation_checker.
module tb_life_automaton_generation_top
  import lifeg_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_COLS      = 32;
  localparam int COL_BITS      = $clog2(MAX_COLS);
  localparam int CELL_TARGET   = 470;  // stop starting generations past this many cells
  localparam int SETTLE_CYCLES = 4;    // row-0 beats emit nothing; let the block go quiet
  localparam int TAIL_CYCLES   = 20;
  // Worst quiet stretch of a correct run is a long stall streak at 72 percent idling
  // or a drain plus a size write; both stay far below this.
  localparam int QUIET_LIMIT   = 2000;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  cfg_we        = 1'b0;
  logic [0:0]            cfg_index     = CFG_GRID_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic                  in_cell_alive = 1'b0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic                  out_next_alive;
  logic [ROW_W-1:0]      out_row;
  logic [COL_BITS-1:0]   out_col;
  logic                  out_gen_last;

  int mismatches;
  int results_pending;
  int results_seen;

  // stimulus bookkeeping
  int                cells_sent   = 0;
  int                generations  = 0;
  int                size_writes  = 0;
  int                cut_writes   = 0;
  int                tx_idle_pct  = 8;
  int                rx_idle_pct  = 72;
  int                eff_w        = GRID_W_RST;
  int                eff_h        = GRID_H_RST;
  logic [CFG_WW-1:0] cur_w_raw    = CFG_WW'(GRID_W_RST);
  int                quiet_cycles = 0;

  life_automaton_generation_top #(
    .MAX_WIDTH (MAX_COLS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cell_alive  (in_cell_alive),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_next_alive (out_next_alive),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_gen_last   (out_gen_last)
  );

  life_generation_checker #(
    .MAX_COLS (MAX_COLS),
    .COL_BITS (COL_BITS)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cell_alive  (in_cell_alive),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_next_alive (out_next_alive),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_gen_last   (out_gen_last),
    .mismatches     (mismatches),
    .pending        (results_pending),
    .results_seen   (results_seen)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Receiver side: stall at random with the current phase's rate.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // Watchdog: end the run once nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results still due",
               QUIET_LIMIT, results_pending);
      $display("status: fail");
      $finish;
    end
  end

  // Send one cell beat. Called and returning at a falling edge; valid stays high on return
  // so back-to-back beats never drop it.
  task automatic send_cell(input logic alive);
    // pick the idling phase: sender light/receiver heavy, then swapped, then none
    if (cells_sent < CELL_TARGET / 3) begin
      tx_idle_pct = 8;
      rx_idle_pct = 72;
    end else if (cells_sent < 2 * CELL_TARGET / 3) begin
      tx_idle_pct = 72;
      rx_idle_pct = 8;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cell_alive <= alive;
    // hold the beat until the block takes it
    do @(posedge clk); while (in_stall !== 1'b0);
    cells_sent++;
    @(negedge clk);
  endtask

  // Drop valid, wait for every expected result, then let the pipeline settle.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write both size registers; junk in the unused upper data bits must be ignored.
  task automatic program_grid_size(input logic [CFG_WW-1:0] w_raw,
                                   input logic [CFG_HW-1:0] h_raw);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'($urandom);
    word[CFG_WW-1:0] = w_raw;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GRID_WIDTH;
    cfg_wdata <= word;
    @(negedge clk);
    cfg_index <= CFG_GRID_HEIGHT;
    cfg_wdata <= h_raw;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    cur_w_raw = w_raw;
    eff_w = (w_raw < SIZE_MIN) ? SIZE_MIN : ((w_raw > MAX_COLS) ? MAX_COLS : int'(w_raw));
    eff_h = (h_raw < SIZE_MIN) ? SIZE_MIN : int'(h_raw);
    size_writes++;
  endtask

  task automatic send_grid_3x3(input logic [8:0] cells);
    for (int i = 0; i < 9; i++) send_cell(cells[i]);
    generations++;
  endtask

  // Stream one generation row by row at the given density. Tall grids are always cut
  // short by a height write at a row boundary; some small ones get a resize there too.
  task automatic run_generation(input int density);
    int row;
    int cut_row;
    bit done;
    row  = 0;
    done = 1'b0;
    if (eff_h > 8) cut_row = $urandom_range(2, 4);
    else if ($urandom_range(5) == 0) cut_row = $urandom_range(1, eff_h - 1);
    else cut_row = -1;
    while (!done) begin
      if (row == cut_row) begin
        hold_until_drained();
        if (eff_h > 8) program_grid_size(cur_w_raw, CFG_HW'($urandom_range(0, row + 1)));
        else program_grid_size(CFG_WW'($urandom_range(0, eff_w)),
                               CFG_HW'($urandom_range(0, 8)));
        cut_writes++;
      end
      for (int col = 0; col < eff_w; col++) send_cell($urandom_range(99) < density);
      done = (row >= eff_h - 1);
      row++;
    end
    generations++;
  endtask

  initial begin
    int sel;
    int density;
    logic [CFG_WW-1:0] w_raw;
    logic [CFG_HW-1:0] h_raw;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: smallest grid, a crowded centre that dies, a birth on exactly three,
    // a survivor on two; the second write uses sizes below the minimum.
    program_grid_size(CFG_WW'(3), CFG_HW'(3));
    send_grid_3x3(9'h1FF);
    hold_until_drained();
    program_grid_size(CFG_WW'(0), CFG_HW'(2));
    send_grid_3x3(9'h007);
    send_grid_3x3(9'h111);

    // Random generations, mostly small; a few wide, clamped or very tall ones.
    while (cells_sent < CELL_TARGET) begin
      if ($urandom_range(99) < 75) begin
        sel = $urandom_range(99);
        if (sel < 55) begin
          w_raw = CFG_WW'($urandom_range(3, 8));
          h_raw = CFG_HW'($urandom_range(3, 6));
        end else if (sel < 65) begin
          w_raw = $urandom_range(1) ? CFG_WW'(MAX_COLS) : CFG_WW'($urandom_range(28, 63));
          h_raw = CFG_HW'($urandom_range(3, 4));
        end else if (sel < 80) begin
          w_raw = CFG_WW'($urandom_range(0, 4));
          h_raw = CFG_HW'($urandom_range(0, 4));
        end else begin
          w_raw = CFG_WW'($urandom_range(3, 5));
          h_raw = $urandom_range(1) ? CFG_HW'(1023) : CFG_HW'($urandom_range(9, 1022));
        end
        hold_until_drained();
        program_grid_size(w_raw, h_raw);
      end
      sel = $urandom_range(9);
      if (sel == 0) density = 0;
      else if (sel == 1) density = 100;
      else density = $urandom_range(15, 70);
      run_generation(density);
    end

    // Drain everything, then give the block time to show any stray beat.
    hold_until_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d cell beats over %0d generations, %0d result beats checked",
             cells_sent, generations, results_seen);
    $display("size writes: %0d, of them %0d inside a generation", size_writes, cut_writes);
    if (mismatches == 0 && results_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
